[sv/ptzs_pkg.sv]
package ptzs_pkg;

  // Width of positions, goals and scan latches (two's complement, wraps).
  localparam int POSITION_BITS = 24;
  // Width of the position fields carried on the input channel.
  localparam int FIELD_BITS    = 24;

  // Port widths; the data widths are padded to whole bytes.
  localparam int IN_DATA_BITS  = ((6 * FIELD_BITS + 1 + 7) / 8) * 8;
  localparam int IN_USER_BITS  = 3;
  localparam int OUT_DATA_BITS = 16;

  typedef logic signed [POSITION_BITS-1:0] pos_t;
  typedef logic signed [FIELD_BITS-1:0]    field_t;

  typedef enum logic [2:0] {
    ACT_PAN_TICK   = 3'd0,
    ACT_TILT_TICK  = 3'd1,
    ACT_HOME       = 3'd2,
    ACT_SCAN_START = 3'd3,
    ACT_STOP       = 3'd4,
    ACT_DISARM     = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_HOMING     = 3'd1,
    MODE_TO_START   = 3'd2,
    MODE_TILT_SWEEP = 3'd3,
    MODE_PAN_STEP   = 3'd4
  } mode_t;

  // One input item.
  typedef struct packed {
    logic [2:0] action;
    field_t     encoder_position;
    logic       encoder_valid;
    field_t     scan_pan_begin;
    field_t     scan_pan_finish;
    field_t     scan_tilt_begin;
    field_t     scan_tilt_finish;
    field_t     scan_pan_increment;
  } item_t;

  // Sequencer state carried from item to item.
  typedef struct packed {
    mode_t mode;
    logic  homed;
    pos_t  pan_pos;
    pos_t  tilt_pos;
    pos_t  pan_goal;
    pos_t  tilt_goal;
    pos_t  pan_end;
    pos_t  tilt_begin;
    pos_t  tilt_end;
    pos_t  pan_incr;
    logic  pan_drv_on;
    logic  tilt_drv_on;
  } state_t;

  // Per-item event and step flags.
  typedef struct packed {
    logic pan_step;
    logic pan_dir;
    logic tilt_step;
    logic tilt_dir;
    logic homed_event;
    logic scan_done_event;
    logic not_homed_error;
  } events_t;

  // Fit an input field to the position width (sign extend or truncate).
  function automatic pos_t fit_field(field_t f);
    logic signed [FIELD_BITS+POSITION_BITS-1:0] wide;
    wide = (FIELD_BITS + POSITION_BITS)'(f);
    return wide[POSITION_BITS-1:0];
  endfunction

endpackage

[sv/ptzs_step.sv]
module ptzs_step (
  input  ptzs_pkg::state_t  st,
  input  ptzs_pkg::item_t   item,
  output ptzs_pkg::state_t  st_nxt,
  output ptzs_pkg::events_t ev
);

  logic                 pan_up;
  logic                 tilt_up;
  ptzs_pkg::pos_t       pan_moved;
  ptzs_pkg::pos_t       tilt_moved;
  logic                 pan_at_goal;
  logic                 tilt_at_goal;
  logic                 pan_past_end;
  ptzs_pkg::pos_t       pan_goal_adv;
  ptzs_pkg::pos_t       tilt_goal_rev;
  ptzs_pkg::state_t     st_home;

  // One step of each axis toward its goal, and the arrival checks.
  always_comb begin
    pan_up       = $signed(st.pan_pos) < $signed(st.pan_goal);
    tilt_up      = $signed(st.tilt_pos) < $signed(st.tilt_goal);
    pan_moved    = pan_up ? st.pan_pos + ptzs_pkg::pos_t'(1) : st.pan_pos - ptzs_pkg::pos_t'(1);
    tilt_moved   = tilt_up ? st.tilt_pos + ptzs_pkg::pos_t'(1)
                           : st.tilt_pos - ptzs_pkg::pos_t'(1);
    pan_at_goal  = st.pan_pos == st.pan_goal;
    tilt_at_goal = st.tilt_pos == st.tilt_goal;
    pan_past_end = $signed(st.pan_pos) >= $signed(st.pan_end);
    pan_goal_adv = st.pan_goal + st.pan_incr;
    tilt_goal_rev = (st.tilt_goal == st.tilt_begin) ? st.tilt_end : st.tilt_begin;
  end

  // State after a homing start; an invalid encoder read keeps the pan position.
  always_comb begin
    st_home           = st;
    if (item.encoder_valid) begin
      st_home.pan_pos = ptzs_pkg::fit_field(item.encoder_position);
    end
    st_home.tilt_pos  = '0;
    st_home.pan_goal  = '0;
    st_home.tilt_goal = '0;
    st_home.mode      = ptzs_pkg::MODE_HOMING;
  end

  // Sequencer decisions for one item.
  always_comb begin
    st_nxt = st;
    ev     = '0;
    unique case (item.action)
      ptzs_pkg::ACT_PAN_TICK: begin
        if (st.mode != ptzs_pkg::MODE_IDLE && st.mode != ptzs_pkg::MODE_TILT_SWEEP) begin
          if (!pan_at_goal) begin
            st_nxt.pan_drv_on = 1'b1;
            st_nxt.pan_pos    = pan_moved;
            ev.pan_step       = 1'b1;
            ev.pan_dir        = pan_up;
          end else if (st.mode == ptzs_pkg::MODE_HOMING) begin
            if (tilt_at_goal) begin
              st_nxt.homed   = 1'b1;
              st_nxt.mode    = ptzs_pkg::MODE_IDLE;
              ev.homed_event = 1'b1;
            end
          end else if (st.mode == ptzs_pkg::MODE_TO_START) begin
            if (tilt_at_goal) begin
              st_nxt.mode      = ptzs_pkg::MODE_TILT_SWEEP;
              st_nxt.tilt_goal = st.tilt_end;
            end
          end else if (st.mode == ptzs_pkg::MODE_PAN_STEP) begin
            if (pan_past_end) begin
              // End of the raster: report it and home again.
              st_nxt             = st_home;
              ev.scan_done_event = 1'b1;
            end else begin
              st_nxt.mode      = ptzs_pkg::MODE_TILT_SWEEP;
              st_nxt.tilt_goal = tilt_goal_rev;
            end
          end
        end
      end
      ptzs_pkg::ACT_TILT_TICK: begin
        if (st.mode != ptzs_pkg::MODE_IDLE && st.mode != ptzs_pkg::MODE_PAN_STEP) begin
          if (!tilt_at_goal) begin
            st_nxt.tilt_drv_on = 1'b1;
            st_nxt.tilt_pos    = tilt_moved;
            ev.tilt_step       = 1'b1;
            ev.tilt_dir        = tilt_up;
          end else if (st.mode == ptzs_pkg::MODE_HOMING) begin
            if (pan_at_goal) begin
              st_nxt.homed   = 1'b1;
              st_nxt.mode    = ptzs_pkg::MODE_IDLE;
              ev.homed_event = 1'b1;
            end
          end else if (st.mode == ptzs_pkg::MODE_TO_START) begin
            if (pan_at_goal) begin
              st_nxt.mode      = ptzs_pkg::MODE_TILT_SWEEP;
              st_nxt.tilt_goal = st.tilt_end;
            end
          end else if (st.mode == ptzs_pkg::MODE_TILT_SWEEP) begin
            // Column finished: advance pan by one increment.
            st_nxt.mode     = ptzs_pkg::MODE_PAN_STEP;
            st_nxt.pan_goal = pan_goal_adv;
          end
        end
      end
      ptzs_pkg::ACT_HOME: begin
        st_nxt = st_home;
      end
      ptzs_pkg::ACT_SCAN_START: begin
        if (!st.homed) begin
          ev.not_homed_error = 1'b1;
        end else begin
          st_nxt.pan_end    = ptzs_pkg::fit_field(item.scan_pan_finish);
          st_nxt.tilt_begin = ptzs_pkg::fit_field(item.scan_tilt_begin);
          st_nxt.tilt_end   = ptzs_pkg::fit_field(item.scan_tilt_finish);
          st_nxt.pan_incr   = ptzs_pkg::fit_field(item.scan_pan_increment);
          st_nxt.pan_goal   = ptzs_pkg::fit_field(item.scan_pan_begin);
          st_nxt.tilt_goal  = ptzs_pkg::fit_field(item.scan_tilt_begin);
          st_nxt.mode       = ptzs_pkg::MODE_TO_START;
        end
      end
      ptzs_pkg::ACT_STOP: begin
        st_nxt.mode = ptzs_pkg::MODE_IDLE;
      end
      ptzs_pkg::ACT_DISARM: begin
        st_nxt.pan_drv_on  = 1'b0;
        st_nxt.tilt_drv_on = 1'b0;
        st_nxt.mode        = ptzs_pkg::MODE_IDLE;
      end
      default: begin
        // Unused action codes leave the state alone.
        st_nxt = st;
      end
    endcase
  end

endmodule

[sv/pan_tilt_zigzag_scan_sequencer.sv]
// Channel | Direction | Handshake          | Contents
// in_     | input     | in_tvalid/tready   | one command or tick per transfer
// out_    | output    | out_tvalid/tready  | one result per input transfer
//
// Each item is held in the input register and is resolved against the
// sequencer state combinationally, so one item per cycle is sustained while out_tready is high.
// A result passes through the input register and then the result register.
// The output register frees the input side: a new item is taken while a
// result waits, and the pipe stalls only when both registers are full.
// Synchronous reset (rst_n low) empties both registers, sets mode idle,
// clears positions, goals and latches and enables both drivers.
module pan_tilt_zigzag_scan_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [23:0] encoder_position, [24] encoder_valid, [48:25] scan_pan_begin,
  // [72:49] scan_pan_finish, [96:73] scan_tilt_begin,
  // [120:97] scan_tilt_finish, [144:121] scan_pan_increment, rest zero
  input  logic [ptzs_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // [2:0] action
  input  logic [ptzs_pkg::IN_USER_BITS-1:0]  in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] pan_step, [1] pan_dir, [2] tilt_step, [3] tilt_dir, [4] pan_driver_on,
  // [5] tilt_driver_on, [6] homed_event, [7] scan_done_event,
  // [8] not_homed_error, [11:9] mode_now, [12] homed_now, [15:13] zero
  output logic [ptzs_pkg::OUT_DATA_BITS-1:0] out_tdata
);

  localparam int FB = ptzs_pkg::FIELD_BITS;

  ptzs_pkg::item_t   item_in;
  ptzs_pkg::item_t   item_r;
  logic              item_vld_r;
  logic              out_vld_r;
  logic [ptzs_pkg::OUT_DATA_BITS-1:0] out_data_r;
  logic [ptzs_pkg::OUT_DATA_BITS-1:0] out_data_nxt;
  ptzs_pkg::state_t  state_r;
  ptzs_pkg::state_t  state_nxt;
  ptzs_pkg::events_t ev;
  logic              advance;

  // Unpack the input transfer.
  always_comb begin
    item_in.action             = in_tuser;
    item_in.encoder_position   = in_tdata[FB-1:0];
    item_in.encoder_valid      = in_tdata[FB];
    item_in.scan_pan_begin     = in_tdata[2*FB:FB+1];
    item_in.scan_pan_finish    = in_tdata[3*FB:2*FB+1];
    item_in.scan_tilt_begin    = in_tdata[4*FB:3*FB+1];
    item_in.scan_tilt_finish   = in_tdata[5*FB:4*FB+1];
    item_in.scan_pan_increment = in_tdata[6*FB:5*FB+1];
  end

  // An item resolves when the result register is free or being drained.
  assign advance   = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;

  ptzs_step u_step (
    .st     (state_r),
    .item   (item_r),
    .st_nxt (state_nxt),
    .ev     (ev)
  );

  // Pack the result from the events and the state after the item.
  assign out_data_nxt = {3'b000,
                         state_nxt.homed,
                         state_nxt.mode,
                         ev.not_homed_error,
                         ev.scan_done_event,
                         ev.homed_event,
                         state_nxt.tilt_drv_on,
                         state_nxt.pan_drv_on,
                         ev.tilt_dir,
                         ev.tilt_step,
                         ev.pan_dir,
                         ev.pan_step};

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      item_r <= item_in;
    end
  end

  // Sequencer state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      // Mode idle, not homed, positions, goals and latches zero, both drivers on.
      state_r   <= {ptzs_pkg::MODE_IDLE, 1'b0,
                    {(8 * ptzs_pkg::POSITION_BITS){1'b0}}, 2'b11};
    end else begin
      if (advance) begin
        state_r   <= state_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
